// ===== rtl/core/tksi_pkg.sv =====
// shared types and constants of the top-k sorted insertion list
`timescale 1ns / 1ps

package tksi_pkg;

    localparam int DEF_MAX_KEEP = 32;
    localparam int DEF_LANES    = 4;
    localparam int IN_LANES     = 4;
    localparam int LANE_W       = 32;
    localparam int TIME_W       = 63;
    localparam int RANK_W       = 5;
    localparam int KEEP_W       = 6;
    localparam int SEL_W        = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_LANE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 2'd2;

    localparam logic [KEEP_W-1:0] KEEP_COUNT_RST = 6'd32;
    localparam logic [SEL_W-1:0]  SCORE_LANE_RST = 2'd0;
    localparam logic              DESCENDING_RST = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]        time_stamp;
        logic signed [LANE_W-1:0] lane_0;
        logic signed [LANE_W-1:0] lane_1;
        logic signed [LANE_W-1:0] lane_2;
        logic signed [LANE_W-1:0] lane_3;
    } t_in;

    typedef struct packed {
        logic [TIME_W-1:0]        out_time;
        logic [RANK_W-1:0]        rank;
        logic signed [LANE_W-1:0] out_lane_0;
        logic signed [LANE_W-1:0] out_lane_1;
        logic signed [LANE_W-1:0] out_lane_2;
        logic signed [LANE_W-1:0] out_lane_3;
        logic                     last_row;
    } t_out;

    typedef struct packed {
        logic [KEEP_W-1:0] keep_count;
        logic [SEL_W-1:0]  score_lane;
        logic              descending;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
        logic pick_new;
        logic last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic beats;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/tksi_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module tksi_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tksi_ctrl.sv =====
// controller: accepts a row, then merges it into the held list one record per cycle while the output is free
`timescale 1ns / 1ps

module tksi_ctrl #(
    parameter int MAX_KEEP = tksi_pkg::DEF_MAX_KEEP,
    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1,
    localparam int CW = $clog2(MAX_KEEP + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tksi_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tksi_pkg::t_stat i_stat,
    output tksi_pkg::t_cmd  o_cmd,
    output logic [IW-1:0]   o_rd_idx,
    output logic [IW-1:0]   o_wr_idx,
    output logic            o_bank
);

    import tksi_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_wr, n_wr;
    logic          r_ins, n_ins;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_bank, n_bank;

    logic          w_accept;
    logic          w_emit;
    logic          w_old_avail;
    logic          w_pick_new;
    logic          w_last;
    logic [CW-1:0] w_k;
    logic [CW:0]   w_n_inc;
    logic [CW-1:0] w_cnt;

    // keep_count of zero acts as one, above the store size as the store size
    always_comb begin
        if (i_cfg.keep_count == '0) begin
            w_k = CW'(1);
        end else if (int'(i_cfg.keep_count) > MAX_KEEP) begin
            w_k = CW'(MAX_KEEP);
        end else begin
            w_k = CW'(i_cfg.keep_count);
        end
    end

    assign w_n_inc     = {1'b0, r_n} + (CW + 1)'(1);
    assign w_cnt       = (w_n_inc < {1'b0, w_k}) ? w_n_inc[CW-1:0] : w_k;
    assign w_accept    = (r_state == ST_IDLE) && i_in_valid;
    assign w_emit      = (r_state == ST_MERGE) && i_stat.out_free;
    assign w_old_avail = r_rd < r_n;
    // new row goes ahead of the first held row that does not beat it
    assign w_pick_new  = !r_ins && (!w_old_avail || !i_stat.beats);
    assign w_last      = ({1'b0, r_wr} + (CW + 1)'(1)) == {1'b0, r_cnt};

    always_comb begin
        n_state = r_state;
        n_rd    = r_rd;
        n_wr    = r_wr;
        n_ins   = r_ins;
        n_n     = r_n;
        n_cnt   = r_cnt;
        n_bank  = r_bank;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MERGE;
                    n_rd    = '0;
                    n_wr    = '0;
                    n_ins   = 1'b0;
                    n_cnt   = w_cnt;
                end
            end
            ST_MERGE: begin
                if (w_emit) begin
                    n_wr = r_wr + CW'(1);
                    if (w_pick_new) begin
                        n_ins = 1'b1;
                    end else begin
                        n_rd = r_rd + CW'(1);
                    end
                    if (w_last) begin
                        n_state = ST_IDLE;
                        n_n     = r_cnt;
                        n_bank  = !r_bank;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rd    <= '0;
            r_wr    <= '0;
            r_ins   <= 1'b0;
            r_n     <= '0;
            r_cnt   <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_ins   <= n_ins;
            r_n     <= n_n;
            r_cnt   <= n_cnt;
            r_bank  <= n_bank;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_cmd.load     = w_accept;
    assign o_cmd.emit     = w_emit;
    assign o_cmd.pick_new = w_pick_new;
    assign o_cmd.last     = w_last;
    // read address runs one ahead so the held row is ready in the ram output
    assign o_rd_idx       = n_rd[IW-1:0];
    assign o_wr_idx       = r_wr[IW-1:0];
    assign o_bank         = r_bank;

endmodule

// ===== rtl/core/tksi_dp.sv =====
// datapath: new row register, score compare, row memory and output register
`timescale 1ns / 1ps

module tksi_dp #(
    parameter int MAX_KEEP = tksi_pkg::DEF_MAX_KEEP,
    parameter int LANES    = tksi_pkg::DEF_LANES,
    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tksi_pkg::t_cfg  i_cfg,
    input  tksi_pkg::t_in   i_in_data,
    input  tksi_pkg::t_cmd  i_cmd,
    output tksi_pkg::t_stat o_stat,
    input  logic [IW-1:0]   i_rd_idx,
    input  logic [IW-1:0]   i_wr_idx,
    input  logic            i_bank,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output tksi_pkg::t_out  o_out_data
);

    import tksi_pkg::*;

    localparam int RW = LANES * LANE_W;

    logic [LANES-1:0][LANE_W-1:0]    r_row;
    logic [TIME_W-1:0]               r_time;
    t_out                            r_out;
    logic                            r_out_valid;

    logic [IN_LANES-1:0][LANE_W-1:0] w_src;
    logic [LANES-1:0][LANE_W-1:0]    w_new;
    logic [LANES-1:0][LANE_W-1:0]    w_old;
    logic [LANES-1:0][LANE_W-1:0]    w_cand;
    logic [IN_LANES-1:0][LANE_W-1:0] w_out_lanes;
    logic [RW-1:0]                   w_rdata;
    logic signed [LANE_W-1:0]        w_e;
    logic signed [LANE_W-1:0]        w_s;
    logic                            w_out_free;

    assign w_src = {i_in_data.lane_3, i_in_data.lane_2, i_in_data.lane_1, i_in_data.lane_0};

    for (genvar g = 0; g < LANES; g++) begin : g_in_lane
        if (g < IN_LANES) begin : g_used
            assign w_new[g] = w_src[g];
        end else begin : g_zero
            assign w_new[g] = '0;
        end
    end

    // bank select in the top address bit: read the held list, write the new one
    tksi_ram #(
        .WIDTH(RW),
        .DEPTH(2 * (1 << IW))
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.emit),
        .i_waddr({!i_bank, i_wr_idx}),
        .i_wdata(w_cand),
        .i_raddr({i_bank, i_rd_idx}),
        .o_rdata(w_rdata)
    );

    assign w_old = w_rdata;

    // score lane outside the row falls back to lane 0
    always_comb begin
        w_e = w_old[0];
        w_s = r_row[0];
        for (int j = 0; j < LANES; j++) begin
            if (int'(i_cfg.score_lane) == j) begin
                w_e = w_old[j];
                w_s = r_row[j];
            end
        end
    end

    assign w_out_free      = !r_out_valid || !i_out_stall;
    assign o_stat.beats    = i_cfg.descending ? (w_e > w_s) : (w_e < w_s);
    assign o_stat.out_free = w_out_free;

    assign w_cand = i_cmd.pick_new ? r_row : w_old;

    for (genvar g = 0; g < IN_LANES; g++) begin : g_out_lane
        if (g < LANES) begin : g_used
            assign w_out_lanes[g] = w_cand[g];
        end else begin : g_zero
            assign w_out_lanes[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row  <= w_new;
            r_time <= i_in_data.time_stamp;
        end
        if (i_cmd.emit) begin
            r_out.out_time   <= r_time;
            r_out.rank       <= RANK_W'(i_wr_idx);
            r_out.out_lane_0 <= w_out_lanes[0];
            r_out.out_lane_1 <= w_out_lanes[1];
            r_out.out_lane_2 <= w_out_lanes[2];
            r_out.out_lane_3 <= w_out_lanes[3];
            r_out.last_row   <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/top_k_sorted_insert.sv =====
// top level of the top-k sorted insertion list: configuration registers and the two halves
`timescale 1ns / 1ps

// Keeps the best keep_count rows, ranked by the chosen score lane, and after
// every input row streams out all held rows best first with the input's
// timestamp, last_row marking the final record. An input row is taken in
// while idle and then produces min(held + 1, K) records, at most MAX_KEEP;
// the input stalls until the last record is emitted, also while the output
// is stalled. The row memory's single read port streams one held row per cycle
// while the output is free, and the merged list is written into the other half
// of the same memory (two banks of 2**IW rows, MAX_KEEP rounded up to a power
// of two, swapped after every transaction). The memory needs no clearing pass.
module top_k_sorted_insert #(
    parameter int MAX_KEEP = tksi_pkg::DEF_MAX_KEEP,
    parameter int LANES    = tksi_pkg::DEF_LANES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tksi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tksi_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tksi_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tksi_pkg::t_out                      o_out_data
);

    import tksi_pkg::*;

    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    t_cfg          r_cfg;
    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [IW-1:0] w_rd_idx;
    logic [IW-1:0] w_wr_idx;
    logic          w_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keep_count <= KEEP_COUNT_RST;
            r_cfg.score_lane <= SCORE_LANE_RST;
            r_cfg.descending <= DESCENDING_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEEP_COUNT: r_cfg.keep_count <= i_cfg_wdata[KEEP_W-1:0];
                CFG_SCORE_LANE: r_cfg.score_lane <= i_cfg_wdata[SEL_W-1:0];
                CFG_DESCENDING: r_cfg.descending <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    tksi_ctrl #(
        .MAX_KEEP(MAX_KEEP)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_rd_idx  (w_rd_idx),
        .o_wr_idx  (w_wr_idx),
        .o_bank    (w_bank)
    );

    tksi_dp #(
        .MAX_KEEP(MAX_KEEP),
        .LANES   (LANES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_rd_idx   (w_rd_idx),
        .i_wr_idx   (w_wr_idx),
        .i_bank     (w_bank),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

endmodule
